FILE: hdl/basic_line_lexer_core_assert.svh
// Assertion macros shared by the lexer RTL.
// All checks are sampled on clk_i and are off while rst_ni is low.
`ifndef BASIC_LINE_LEXER_CORE_ASSERT_SVH
`define BASIC_LINE_LEXER_CORE_ASSERT_SVH

// Plain property check.
`define BLL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication check.
`define BLL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define BLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bll_pkg.sv
package bll_pkg;

  // Token kinds
  localparam logic [3:0] K_END     = 4'd0;
  localparam logic [3:0] K_LET     = 4'd1;
  localparam logic [3:0] K_PRINT   = 4'd2;
  localparam logic [3:0] K_INPUT   = 4'd3;
  localparam logic [3:0] K_NUMBER  = 4'd4;
  localparam logic [3:0] K_LABEL   = 4'd5;
  localparam logic [3:0] K_ADD     = 4'd6;
  localparam logic [3:0] K_SUB     = 4'd7;
  localparam logic [3:0] K_MUL     = 4'd8;
  localparam logic [3:0] K_DIV     = 4'd9;
  localparam logic [3:0] K_EQUAL   = 4'd10;
  localparam logic [3:0] K_STRING  = 4'd11;
  localparam logic [3:0] K_LPAREN  = 4'd12;
  localparam logic [3:0] K_RPAREN  = 4'd13;
  localparam logic [3:0] K_COMMA   = 4'd14;
  localparam logic [3:0] K_INVALID = 4'd15;

  // Pending-token code for "nothing pending"
  localparam logic [3:0] K_NONE    = 4'd0;

  localparam logic [2:0] ALL_CANDIDATES = 3'b111;

  // Characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [3:0] kind;
    logic [5:0] start;
    logic [6:0] length;
    logic       eol;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // Keyword table: 0 LET, 1 PRINT, 2 INPUT
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    case (k)
      2'd0:    len = 3'd3;
      2'd1:    len = 3'd5;
      2'd2:    len = 3'd5;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] k);
    logic [3:0] kind;
    case (k)
      2'd0:    kind = K_LET;
      2'd1:    kind = K_PRINT;
      2'd2:    kind = K_INPUT;
      default: kind = K_LABEL;
    endcase
    return kind;
  endfunction

  function automatic logic [7:0] kw_letter(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    case ({k, pos})
      {2'd0, 3'd0}: ch = "L";
      {2'd0, 3'd1}: ch = "E";
      {2'd0, 3'd2}: ch = "T";
      {2'd1, 3'd0}: ch = "P";
      {2'd1, 3'd1}: ch = "R";
      {2'd1, 3'd2}: ch = "I";
      {2'd1, 3'd3}: ch = "N";
      {2'd1, 3'd4}: ch = "T";
      {2'd2, 3'd0}: ch = "I";
      {2'd2, 3'd1}: ch = "N";
      {2'd2, 3'd2}: ch = "P";
      {2'd2, 3'd3}: ch = "U";
      {2'd2, 3'd4}: ch = "T";
      default:      ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Single-character tokens; anything else that gets here is invalid
  function automatic logic [3:0] single_kind(input logic [7:0] c);
    logic [3:0] kind;
    case (c)
      "+":     kind = K_ADD;
      "-":     kind = K_SUB;
      "*":     kind = K_MUL;
      "/":     kind = K_DIV;
      "=":     kind = K_EQUAL;
      "(":     kind = K_LPAREN;
      ")":     kind = K_RPAREN;
      ",":     kind = K_COMMA;
      default: kind = K_INVALID;
    endcase
    return kind;
  endfunction

endpackage

FILE: hdl/bll_out_fifo.sv
`include "basic_line_lexer_core_assert.svh"

module bll_out_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bll_pkg::push_t            push_i,
  input  bll_pkg::result_t          data0_i,
  input  bll_pkg::result_t          data1_i,
  input  logic                      pop_i,
  output bll_pkg::result_t          head_o,
  output logic [bll_pkg::FIFO_AW:0] count_o
);

  bll_pkg::result_t mem_q [bll_pkg::FIFO_DEPTH];

  logic [bll_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [bll_pkg::FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [bll_pkg::FIFO_AW:0]   count_q, count_d;
  logic [bll_pkg::FIFO_AW:0]   n_push;
  logic [bll_pkg::FIFO_AW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_q + 1'b1;
  assign n_push    = (bll_pkg::FIFO_AW+1)'(push_i.first) + (bll_pkg::FIFO_AW+1)'(push_i.second);

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push[bll_pkg::FIFO_AW-1:0];
    rd_ptr_d = rd_ptr_q + (bll_pkg::FIFO_AW)'(pop_i);
    count_d  = count_q + n_push - (bll_pkg::FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_i.second) begin
      mem_q[wr_ptr_p1] <= data1_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  `BLL_ASSERT(a_fifo_bound, count_q <= (bll_pkg::FIFO_AW+1)'(bll_pkg::FIFO_DEPTH),
              "result queue overfilled")
  `BLL_ASSERT_IMP(a_fifo_pair, push_i.second, push_i.first,
                  "second slot pushed without the first")
  `BLL_ASSERT_IMP(a_fifo_no_underflow, pop_i, count_q != '0,
                  "pop from empty result queue")

endmodule

FILE: hdl/basic_line_lexer_core.sv
// Streaming BASIC line lexer, one character item per unstalled cycle.
// The item that ends a token passes through the input register, then the lexer
// step writes the token into the result queue, whose head drives the output.
// Throughput: 1 item per cycle while the 4-entry result queue has room for
// two results; items yield 0, 1 or 2 results, drained one per unstalled cycle.
// Reset (rst_ni low, async): no token pending, column 0, queue empty.
`include "basic_line_lexer_core_assert.svh"

module basic_line_lexer_core #(
  parameter int LINE_SIZE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input item channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  // result item channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] kind_o,
  output logic [5:0] start_column_o,
  output logic [6:0] token_length_o,
  output logic       end_of_line_o
);

  // Column and length counters both saturate at LINE_SIZE.
  localparam int            CW       = $clog2(LINE_SIZE + 1);
  localparam logic [CW-1:0] LAST_COL = CW'(LINE_SIZE - 1);
  localparam logic [CW-1:0] MAX_COL  = CW'(LINE_SIZE);

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       room;
  logic       consume;
  logic       in_accept;

  logic [bll_pkg::FIFO_AW:0] fifo_count;

  // Room is judged from the registered queue count only, so the stall does
  // not depend combinationally on out_stall_i.
  assign room       = fifo_count <= (bll_pkg::FIFO_AW+1)'(bll_pkg::FIFO_DEPTH - 2);
  assign consume    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_code_i;
    end
  end

  // ---------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------
  logic [3:0]    pend_kind_q, pend_kind_d;
  logic [CW-1:0] pend_start_q, pend_start_d;
  logic [CW-1:0] pend_len_q, pend_len_d;
  logic [2:0]    cand_q, cand_d;
  logic [CW-1:0] column_q, column_d;
  logic          discard_q, discard_d;

  // Drop keyword candidates whose letter at pos differs from c.
  function automatic logic [2:0] narrow(input logic [2:0] cand, input logic [7:0] c,
                                        input logic [CW-1:0] pos);
    logic [2:0] keep;
    keep = cand;
    for (int k = 0; k < 3; k++) begin
      if (!(pos < CW'(bll_pkg::kw_len(2'(k))) &&
            c == bll_pkg::kw_letter(2'(k), pos[2:0]))) begin
        keep[k] = 1'b0;
      end
    end
    return keep;
  endfunction

  // ---------------------------------------------------------------------
  // Lexer step
  // ---------------------------------------------------------------------
  logic [7:0]       c;
  logic             is_upper, is_digit, is_label_tail;
  logic [CW-1:0]    col;
  logic [CW-1:0]    grown_len;
  logic [CW-1:0]    flush_len;
  logic [3:0]       flush_kind;
  logic             flush_v, tok_v;
  bll_pkg::result_t flush_res, tok_res;
  bll_pkg::result_t res0, res1;
  bll_pkg::push_t   push;

  assign c             = char_q;
  assign is_upper      = (c >= "A") && (c <= "Z");
  assign is_digit      = (c >= "0") && (c <= "9");
  assign is_label_tail = is_upper || (c == bll_pkg::CH_PERCENT) || (c == bll_pkg::CH_DOLLAR);
  assign col           = (column_q < LAST_COL) ? column_q : LAST_COL;
  assign grown_len     = (pend_len_q < MAX_COL) ? pend_len_q + 1'b1 : pend_len_q;

  // Pending label resolves to a keyword when the spelling matched in full.
  always_comb begin
    flush_kind = pend_kind_q;
    if (pend_kind_q == bll_pkg::K_LABEL) begin
      for (int k = 2; k >= 0; k--) begin
        if (cand_q[k] && pend_len_q == CW'(bll_pkg::kw_len(2'(k)))) begin
          flush_kind = bll_pkg::kw_kind(2'(k));
        end
      end
    end
  end

  always_comb begin
    pend_kind_d  = pend_kind_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    cand_d       = cand_q;
    column_d     = column_q;
    discard_d    = discard_q;
    flush_v      = 1'b0;
    flush_len    = pend_len_q;
    tok_v        = 1'b0;
    tok_res      = '0;

    if (consume) begin
      if (c == bll_pkg::CH_NUL) begin
        // End of line: flush whatever is pending, then the end token.
        flush_v        = pend_kind_q != bll_pkg::K_NONE;
        tok_v          = 1'b1;
        tok_res.kind   = bll_pkg::K_END;
        tok_res.start  = 6'(col);
        tok_res.length = 7'd0;
        tok_res.eol    = 1'b1;
        pend_kind_d    = bll_pkg::K_NONE;
        pend_start_d   = '0;
        pend_len_d     = '0;
        cand_d         = bll_pkg::ALL_CANDIDATES;
        column_d       = '0;
        discard_d      = 1'b0;
      end else begin
        column_d = (column_q < MAX_COL) ? column_q + 1'b1 : column_q;
        if (discard_q) begin
          // rest of line is skipped
        end else if (pend_kind_q == bll_pkg::K_STRING) begin
          pend_len_d = grown_len;
          if (c == bll_pkg::CH_QUOTE) begin
            // closing quote is part of the string
            flush_v      = 1'b1;
            flush_len    = grown_len;
            pend_kind_d  = bll_pkg::K_NONE;
            pend_start_d = '0;
            pend_len_d   = '0;
            cand_d       = bll_pkg::ALL_CANDIDATES;
          end
        end else if (pend_kind_q == bll_pkg::K_LABEL && is_label_tail) begin
          cand_d     = narrow(cand_q, c, pend_len_q);
          pend_len_d = grown_len;
        end else if (pend_kind_q == bll_pkg::K_NUMBER && is_digit) begin
          pend_len_d = grown_len;
        end else begin
          // Token boundary: close the pending token, then look at c afresh.
          flush_v      = pend_kind_q != bll_pkg::K_NONE;
          pend_kind_d  = bll_pkg::K_NONE;
          pend_start_d = '0;
          pend_len_d   = '0;
          cand_d       = bll_pkg::ALL_CANDIDATES;
          if (c == bll_pkg::CH_SPACE) begin
            // separator only
          end else if (is_digit) begin
            pend_kind_d  = bll_pkg::K_NUMBER;
            pend_start_d = col;
            pend_len_d   = CW'(1);
          end else if (is_upper) begin
            pend_kind_d  = bll_pkg::K_LABEL;
            pend_start_d = col;
            pend_len_d   = CW'(1);
            cand_d       = narrow(bll_pkg::ALL_CANDIDATES, c, '0);
          end else if (c == bll_pkg::CH_QUOTE) begin
            pend_kind_d  = bll_pkg::K_STRING;
            pend_start_d = col;
            pend_len_d   = CW'(1);
          end else begin
            // one-character token; an invalid one kills the rest of the line
            tok_v          = 1'b1;
            tok_res.kind   = bll_pkg::single_kind(c);
            tok_res.start  = 6'(col);
            tok_res.length = 7'd1;
            tok_res.eol    = 1'b0;
            discard_d      = bll_pkg::single_kind(c) == bll_pkg::K_INVALID;
          end
        end
      end
    end
  end

  always_comb begin
    flush_res.kind   = flush_kind;
    flush_res.start  = 6'(pend_start_q);
    flush_res.length = 7'(flush_len);
    flush_res.eol    = 1'b0;
  end

  // Flushed token always goes ahead of the new one.
  assign res0        = flush_v ? flush_res : tok_res;
  assign res1        = tok_res;
  assign push.first  = flush_v || tok_v;
  assign push.second = flush_v && tok_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_kind_q  <= bll_pkg::K_NONE;
      pend_start_q <= '0;
      pend_len_q   <= '0;
      cand_q       <= bll_pkg::ALL_CANDIDATES;
      column_q     <= '0;
      discard_q    <= 1'b0;
    end else begin
      pend_kind_q  <= pend_kind_d;
      pend_start_q <= pend_start_d;
      pend_len_q   <= pend_len_d;
      cand_q       <= cand_d;
      column_q     <= column_d;
      discard_q    <= discard_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue and output
  // ---------------------------------------------------------------------
  bll_pkg::result_t head;
  logic             pop;

  assign out_valid_o = fifo_count != '0;
  assign pop         = out_valid_o && !out_stall_i;

  bll_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (res0),
    .data1_i (res1),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  assign kind_o         = head.kind;
  assign start_column_o = head.start;
  assign token_length_o = head.length;
  assign end_of_line_o  = head.eol;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `BLL_ASSERT_IMP(a_discard_idle, discard_q, pend_kind_q == bll_pkg::K_NONE,
                  "token pending while discarding")
  `BLL_ASSERT(a_len_bound, pend_len_q <= MAX_COL, "pending length past line size")
  `BLL_ASSERT_NEXT(a_eol_clears, consume && (char_q == bll_pkg::CH_NUL),
                   (column_q == '0) && (pend_kind_q == bll_pkg::K_NONE) && !discard_q,
                   "line state not cleared after end of line")
  `BLL_ASSERT_IMP(a_eol_shape, out_valid_o && end_of_line_o,
                  (kind_o == bll_pkg::K_END) && (token_length_o == 7'd0),
                  "malformed end token")

endmodule
